// File: src/pdc_pkg.sv
// ----------------------------------------------------------------------------
// Porter-Duff compositor package
// Shared widths, mode codes, register indexes and the divide-by-255 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pdc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned GainW  = 16;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [ChanW-1:0] MaxChan = 8'd255;
  localparam logic signed [ChanW+1:0] MaxChanS = 10'sd255;

  localparam logic [1:0] ModeOver  = 2'd0;
  localparam logic [1:0] ModeIn    = 2'd1;
  localparam logic [1:0] ModeArith = 2'd2;

  localparam logic [2:0] RegMode        = 3'd0;
  localparam logic [2:0] RegGainProduct = 3'd1;
  localparam logic [2:0] RegGainSource  = 3'd2;
  localparam logic [2:0] RegGainDest    = 3'd3;
  localparam logic [2:0] RegGainOffset  = 3'd4;

  typedef logic [NumCh-1:0][ChanW-1:0] pix_t;
  typedef logic [NumCh-1:0][ProdW-1:0] prod_t;

  // exact floor(x / 255) for x up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{(ChanW+1){1'b0}}, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// File: src/pdc_in_if.sv
// ----------------------------------------------------------------------------
// Compositor input channel
// Valid/ready channel carrying one source and one destination ARGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdc_in_if;
  logic                      valid;
  logic                      ready;
  logic [pdc_pkg::ChanW-1:0] src_red;
  logic [pdc_pkg::ChanW-1:0] src_green;
  logic [pdc_pkg::ChanW-1:0] src_blue;
  logic [pdc_pkg::ChanW-1:0] src_alpha;
  logic [pdc_pkg::ChanW-1:0] dst_red;
  logic [pdc_pkg::ChanW-1:0] dst_green;
  logic [pdc_pkg::ChanW-1:0] dst_blue;
  logic [pdc_pkg::ChanW-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

`default_nettype wire

// File: src/pdc_out_if.sv
// ----------------------------------------------------------------------------
// Compositor output channel
// Valid/ready channel carrying one composited ARGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdc_out_if;
  logic                      valid;
  logic                      ready;
  logic [pdc_pkg::ChanW-1:0] out_red;
  logic [pdc_pkg::ChanW-1:0] out_green;
  logic [pdc_pkg::ChanW-1:0] out_blue;
  logic [pdc_pkg::ChanW-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

`default_nettype wire

// File: src/porter_duff_pixel_compositor.sv
// ----------------------------------------------------------------------------
// Porter-Duff pixel compositor
// Composites a source ARGB pixel onto a destination pixel per request.
// ----------------------------------------------------------------------------
// in_i carries a source/destination pixel pair, out_o carries the
// composited pixel; both are valid/ready channels. The APB port sets the
// mode (over, in, arithmetic) and the four signed gains of the arithmetic
// rule; program it only while no request is in flight.
// An accepted request passes the product, divide and sum registers in turn
// before it shows on out_o. Throughput is one request per cycle while out_o
// does not stall, set by the three-stage product/divide/sum pipeline.
// Each stage holds its own valid bit and advances when the next stage is
// empty or advancing, so a stall on out_o fills the empty stages first and
// only then drops in_i.ready; nothing is lost or repeated.
// Reset clears the pipeline valid bits and the registers (mode over, gains
// zero). Mode code 3 yields an all-zero pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module porter_duff_pixel_compositor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pdc_in_if.sink                           in_i,
  pdc_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pdc_pkg::AddrW-1:0]   paddr,
  input  wire logic [pdc_pkg::DataW-1:0]   pwdata,
  output logic      [pdc_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned W  = pdc_pkg::ChanW;
  localparam int unsigned N  = pdc_pkg::NumCh;
  localparam int unsigned GW = pdc_pkg::GainW;
  localparam int unsigned PW = pdc_pkg::ProdW;
  localparam int unsigned PsW  = GW + PW + 1;
  localparam int unsigned LinW = GW + W + 1;
  localparam int unsigned OffW = GW + W + 2;
  localparam int unsigned SumW = PsW + 1;

  // configuration registers
  logic [1:0]           mode_q;
  logic signed [GW-1:0] gain_product_q, gain_source_q, gain_dest_q, gain_offset_q;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[pdc_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= pdc_pkg::ModeOver;
      gain_product_q <= '0;
      gain_source_q  <= '0;
      gain_dest_q    <= '0;
      gain_offset_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        pdc_pkg::RegMode:        mode_q         <= pwdata[1:0];
        pdc_pkg::RegGainProduct: gain_product_q <= pwdata[GW-1:0];
        pdc_pkg::RegGainSource:  gain_source_q  <= pwdata[GW-1:0];
        pdc_pkg::RegGainDest:    gain_dest_q    <= pwdata[GW-1:0];
        pdc_pkg::RegGainOffset:  gain_offset_q  <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pdc_pkg::RegMode:        prdata = {30'd0, mode_q};
      pdc_pkg::RegGainProduct: prdata = 32'(gain_product_q);
      pdc_pkg::RegGainSource:  prdata = 32'(gain_source_q);
      pdc_pkg::RegGainDest:    prdata = 32'(gain_dest_q);
      pdc_pkg::RegGainOffset:  prdata = 32'(gain_offset_q);
      default:                 prdata = '0;
    endcase
  end

  // pipeline control
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3, in_fire;

  assign en3      = !v3_q || out_o.ready;
  assign en2      = !v2_q || en3;
  assign en1      = !v1_q || en2;
  assign in_i.ready = en1;
  assign in_fire  = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: channel products
  pdc_pkg::pix_t  s_in, d_in, s1_q, d1_q;
  pdc_pkg::prod_t prod1_d, prod1_q;

  assign s_in = {in_i.src_alpha, in_i.src_blue, in_i.src_green, in_i.src_red};
  assign d_in = {in_i.dst_alpha, in_i.dst_blue, in_i.dst_green, in_i.dst_red};

  always_comb begin
    for (int i = 0; i < N; i++) begin
      case (mode_q)
        pdc_pkg::ModeOver: prod1_d[i] = PW'(d_in[i]) * PW'(pdc_pkg::MaxChan - s_in[N-1]);
        pdc_pkg::ModeIn:   prod1_d[i] = PW'(s_in[i]) * PW'(d_in[N-1]);
        default:           prod1_d[i] = PW'(s_in[i]) * PW'(d_in[i]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q    <= s_in;
      d1_q    <= d_in;
      prod1_q <= prod1_d;
    end
  end

  // stage 2: divide by 255 and gain products
  pdc_pkg::pix_t                         s2_q, q2_q;
  logic signed [N-1:0][PsW-1:0]          ps2_q;
  logic signed [N-1:0][LinW-1:0]         ls2_q, ld2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_q <= s1_q;
      for (int i = 0; i < N; i++) begin
        q2_q[i]  <= pdc_pkg::div255(prod1_q[i]);
        ps2_q[i] <= gain_product_q * $signed({1'b0, prod1_q[i]});
        ls2_q[i] <= gain_source_q * $signed({1'b0, s1_q[i]});
        ld2_q[i] <= gain_dest_q * $signed({1'b0, d1_q[i]});
      end
    end
  end

  // stage 3: sum, saturate and select
  logic signed [OffW-1:0] offset;
  logic signed [SumW-1:0] sum [N];
  logic [W:0]             over_sum [N];
  pdc_pkg::pix_t          res3_d, res3_q;

  assign offset = gain_offset_q * pdc_pkg::MaxChanS;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sum[i] = SumW'($signed(ps2_q[i])) + SumW'($signed(ls2_q[i]))
             + SumW'($signed(ld2_q[i])) + SumW'(offset);
      over_sum[i] = {1'b0, s2_q[i]} + {1'b0, q2_q[i]};
      case (mode_q)
        pdc_pkg::ModeOver:
          res3_d[i] = over_sum[i][W] ? pdc_pkg::MaxChan : over_sum[i][W-1:0];
        pdc_pkg::ModeIn:
          res3_d[i] = q2_q[i];
        pdc_pkg::ModeArith: begin
          if (sum[i] < 0) res3_d[i] = '0;
          else if (sum[i] > SumW'(pdc_pkg::MaxChanS)) res3_d[i] = pdc_pkg::MaxChan;
          else res3_d[i] = sum[i][W-1:0];
        end
        default: res3_d[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) res3_q <= res3_d;
  end

  assign out_o.valid     = v3_q;
  assign out_o.out_red   = res3_q[0];
  assign out_o.out_green = res3_q[1];
  assign out_o.out_blue  = res3_q[2];
  assign out_o.out_alpha = res3_q[3];

  // checks
  a_fire_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> v1_q)
    else $error("accepted request did not enter stage 1");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline full and stalled");

  a_bubble_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q || !v2_q || !v3_q) |-> in_i.ready)
    else $error("input dropped ready with an empty stage");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !out_o.ready) |=> (v3_q && $stable(res3_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
